// ===== hdl/pws_pkg.sv =====
// Shared types and constants for the pressure window stability block.
// Holds the payload word structs, the mode codes and the internal control structs.
// No dependencies.
package pws_pkg;

	localparam int PRESSURE_W = 24;
	localparam int WINDOW_DEPTH_DEF = 16;
	localparam logic [PRESSURE_W-1:0] THRESHOLD_RESET = 24'd1229;

	localparam logic MODE_UPDATE = 1'b0;
	localparam logic MODE_PRIME = 1'b1;

	typedef struct packed {
		logic mode;
		logic [PRESSURE_W-1:0] raw_pressure;
		logic read_ok;
	} pws_in_t;

	typedef struct packed {
		logic [PRESSURE_W-1:0] pressure_counts;
		logic stable;
	} pws_out_t;

	// Window memory control from the sequencer.
	typedef struct packed {
		logic wr_en;
		logic rd_en;
		logic prime;
	} pws_win_ctrl_t;

	// Accumulator step that travels alongside the read data.
	typedef struct packed {
		logic valid;
		logic first;
	} pws_acc_t;

endpackage

// ===== hdl/pws_window.sv =====
// Sample window memory with one write port and one registered read port.
// Per-entry valid bits let reset and prime act at once; a stale entry reads as the base value.
// Depends on pws_pkg.
module pws_window #(
	parameter int DEPTH = pws_pkg::WINDOW_DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  pws_pkg::pws_win_ctrl_t         ctrl,
	input  logic [$clog2(DEPTH)-1:0]       wr_addr,
	input  logic [pws_pkg::PRESSURE_W-1:0] wr_data,
	input  logic [$clog2(DEPTH)-1:0]       rd_addr,
	input  logic [pws_pkg::PRESSURE_W-1:0] prime_data,
	output logic [pws_pkg::PRESSURE_W-1:0] rd_data
);

	logic [pws_pkg::PRESSURE_W-1:0] mem [DEPTH];
	logic [pws_pkg::PRESSURE_W-1:0] rd_q;
	logic [pws_pkg::PRESSURE_W-1:0] base_q;
	logic [DEPTH-1:0]               valid_q;
	logic                           rd_vld_q;

	always_ff @(posedge clk) begin
		if (ctrl.wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (ctrl.rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			base_q   <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			// A prime makes every entry hold the sample without touching the array.
			if (ctrl.prime) begin
				valid_q <= '0;
				base_q  <= prime_data;
			end else if (ctrl.wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (ctrl.rd_en) begin
				rd_vld_q <= valid_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_vld_q ? rd_q : base_q;

	a_no_wr_during_rd: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.rd_en |-> !ctrl.wr_en && !ctrl.prime)
		else $error("window written while being scanned");

	a_write_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.wr_en && !ctrl.prime |=> valid_q[$past(wr_addr)])
		else $error("written entry not marked valid");

	a_prime_clears: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.prime |=> valid_q == '0)
		else $error("prime left valid entries");

endmodule

// ===== hdl/pws_minmax.sv =====
// Running minimum and maximum over the words read out of the window.
// Restarts on the step marked first and folds in one word a cycle.
// Depends on pws_pkg.
module pws_minmax (
	input  logic                           clk,
	input  logic                           arst_n,
	input  pws_pkg::pws_acc_t              step,
	input  logic [pws_pkg::PRESSURE_W-1:0] data,
	output logic [pws_pkg::PRESSURE_W-1:0] min_val,
	output logic [pws_pkg::PRESSURE_W-1:0] max_val
);

	logic [pws_pkg::PRESSURE_W-1:0] min_q;
	logic [pws_pkg::PRESSURE_W-1:0] max_q;
	logic                           have_q;

	always_ff @(posedge clk) begin
		if (step.valid) begin
			if (step.first || data < min_q) begin
				min_q <= data;
			end
			if (step.first || data > max_q) begin
				max_q <= data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q <= 1'b0;
		end else if (step.valid) begin
			have_q <= 1'b1;
		end
	end

	assign min_val = min_q;
	assign max_val = max_q;

	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		have_q |-> min_q <= max_q)
		else $error("minimum above maximum");

	a_first_loads: assert property (@(posedge clk) disable iff (!arst_n)
		step.valid && step.first |=> min_q == max_q)
		else $error("first word did not load both bounds");

	a_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		step.valid && !step.first && have_q |=> min_q <= $past(min_q) && max_q >= $past(max_q))
		else $error("bounds moved the wrong way");

endmodule

// ===== hdl/pressure_window_stability_top.sv =====
// Pressure window stability detector: an accepted update word is written into the window,
// then the one read port of the window memory scans every entry, one per cycle, to find the
// minimum and maximum in ST_SCAN; the last read is folded in during ST_DRAIN, and ST_DONE
// loads the result into the output register. The next sample word is taken only once the
// state is back in ST_IDLE, so no update word is taken before the last one is done. A prime
// word goes from ST_IDLE straight to ST_DONE and does no scan. One word is in work at a time;
// the result sits in an output register, so the next sample is taken while a result still
// waits to be taken, and a word that finishes while that register is still full waits until
// it is free. No clearing pass is needed after reset. Depends on pws_pkg, pws_window and
// pws_minmax.
module pressure_window_stability_top #(
	parameter int WINDOW_DEPTH = pws_pkg::WINDOW_DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           sample_valid,
	output logic                           sample_stall,
	input  pws_pkg::pws_in_t               sample,
	output logic                           result_valid,
	input  logic                           result_stall,
	output pws_pkg::pws_out_t              result,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [pws_pkg::PRESSURE_W-1:0] cfg_data
);

	localparam int AW = $clog2(WINDOW_DEPTH);
	localparam logic [AW-1:0] LAST_SLOT = AW'(WINDOW_DEPTH - 1);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SCAN  = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;
	localparam logic [1:0] ST_DONE  = 2'd3;

	logic [1:0]                     state_q;
	logic [AW-1:0]                  slot_q;
	logic [AW-1:0]                  rd_addr_q;
	logic [pws_pkg::PRESSURE_W-1:0] cur_q;
	logic [pws_pkg::PRESSURE_W-1:0] thr_q;
	logic                           stable_q;
	logic                           upd_q;
	logic                           res_valid_q;
	pws_pkg::pws_out_t              res_q;
	pws_pkg::pws_acc_t              acc_s1;

	pws_pkg::pws_win_ctrl_t         win_ctrl;
	logic [pws_pkg::PRESSURE_W-1:0] next_cur;
	logic [pws_pkg::PRESSURE_W-1:0] win_data;
	logic [pws_pkg::PRESSURE_W-1:0] min_val;
	logic [pws_pkg::PRESSURE_W-1:0] max_val;
	logic [pws_pkg::PRESSURE_W-1:0] spread;
	logic                           accept;
	logic                           is_prime;
	logic                           out_free;
	logic                           stable_next;

	assign sample_stall = (state_q != ST_IDLE);
	assign accept       = sample_valid && !sample_stall;
	assign is_prime     = (sample.mode == pws_pkg::MODE_PRIME);
	assign next_cur     = sample.read_ok ? sample.raw_pressure : cur_q;
	assign out_free     = !res_valid_q || !result_stall;
	assign spread       = max_val - min_val;
	assign stable_next  = (spread < thr_q);

	always_comb begin
		win_ctrl.wr_en = accept && !is_prime;
		win_ctrl.prime = accept && is_prime && sample.read_ok;
		win_ctrl.rd_en = (state_q == ST_SCAN);
	end

	pws_window #(
		.DEPTH(WINDOW_DEPTH)
	) u_window (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (win_ctrl),
		.wr_addr   (slot_q),
		.wr_data   (next_cur),
		.rd_addr   (rd_addr_q),
		.prime_data(sample.raw_pressure),
		.rd_data   (win_data)
	);

	pws_minmax u_minmax (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (acc_s1),
		.data   (win_data),
		.min_val(min_val),
		.max_val(max_val)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= pws_pkg::THRESHOLD_RESET;
		end else if (cfg_valid) begin
			thr_q <= cfg_data;
		end
	end

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			res_q.pressure_counts <= cur_q;
			res_q.stable          <= upd_q ? stable_next : stable_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			slot_q      <= '0;
			rd_addr_q   <= '0;
			cur_q       <= '0;
			stable_q    <= 1'b0;
			upd_q       <= 1'b0;
			res_valid_q <= 1'b0;
			acc_s1      <= '0;
		end else begin
			// A finished word reloads the output register below in the same cycle.
			if (res_valid_q && !result_stall && state_q != ST_DONE) begin
				res_valid_q <= 1'b0;
			end
			// The read issued this cycle comes back next cycle with its step marker.
			acc_s1.valid <= (state_q == ST_SCAN);
			acc_s1.first <= (rd_addr_q == '0);
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						upd_q     <= !is_prime;
						rd_addr_q <= '0;
						if (is_prime) begin
							state_q <= ST_DONE;
						end else begin
							cur_q   <= next_cur;
							slot_q  <= (slot_q == LAST_SLOT) ? '0 : AW'(slot_q + 1'b1);
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					rd_addr_q <= (rd_addr_q == LAST_SLOT) ? '0 : AW'(rd_addr_q + 1'b1);
					if (rd_addr_q == LAST_SLOT) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						res_valid_q <= 1'b1;
						if (upd_q) begin
							stable_q <= stable_next;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> sample_stall)
		else $error("sample taken without going busy");

	a_done_delivers: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DONE && out_free |=> result_valid && !sample_stall)
		else $error("finished word not placed in output register");

	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		slot_q <= LAST_SLOT && rd_addr_q <= LAST_SLOT)
		else $error("window address out of range");

	a_scan_to_drain: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN && rd_addr_q == LAST_SLOT |=> state_q == ST_DRAIN && acc_s1.valid)
		else $error("scan did not end on the last entry");

endmodule
